[src/cma_pkg.sv]
// Shared constants for the centered moving average block.
package cma_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int MAX_HALF     = 15;
  localparam int DEPTH        = 2 * MAX_HALF + 1;
  localparam int AW           = $clog2(DEPTH);
  localparam int CNT_W        = $clog2(DEPTH + 1);
  localparam int HW_W         = 4;
  localparam int RECIP_W      = 17;
  localparam int FRAC_W       = 16;
  localparam int SUM_W        = SAMPLE_WIDTH + AW;
  localparam int PROD_W       = SUM_W + RECIP_W;
  localparam int Q_W          = PROD_W + 1 - FRAC_W;
  localparam int CFG_W        = RECIP_W;
  localparam int CFG_IDX_W    = 1;

  localparam int POS_LIM = 2 ** (SAMPLE_WIDTH - 1) - 1;
  localparam int NEG_LIM = 2 ** (SAMPLE_WIDTH - 1);

  localparam logic [SAMPLE_WIDTH-1:0] SMAX = {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
  localparam logic [SAMPLE_WIDTH-1:0] SMIN = {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};
  localparam logic [CNT_W-1:0]        CNT_SAT = '1;

  localparam logic [HW_W-1:0]    HALF_RESET  = 4'd1;
  localparam logic [RECIP_W-1:0] RECIP_RESET = 17'd21845;

  localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_RECIP = 1'd1;

endpackage

[src/cma_if.sv]
// Valid/ready channel interfaces for the sample and result streams.
interface cma_in_if import cma_pkg::*; ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic                           final_sample;

  modport source (output valid, sample, final_sample, input ready);
  modport sink   (input valid, sample, final_sample, output ready);
endinterface

interface cma_out_if import cma_pkg::*; ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] smoothed;
  logic                           was_averaged;
  logic                           end_of_series;

  modport source (output valid, smoothed, was_averaged, end_of_series, input ready);
  modport sink   (input valid, smoothed, was_averaged, end_of_series, output ready);
endinterface

[src/cma_ram.sv]
// Generic RAM: one write port, two registered read ports, read-first.
module cma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 31
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic                     re_b,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  // a read of the address being written returns the old word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re_a) begin
      rdata_a_r <= mem[raddr_a];
    end
    if (re_b) begin
      rdata_b_r <= mem[raddr_b];
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

[src/centered_moving_average.sv]
// Centered moving average: window store, running sum, mean pipeline, flush sequencer.
// Path: the first result of an item passes stages 1 to 4 and then the output register;
//   flush results of a final item follow, one per cycle while the output is not stalled.
// Throughput: one item per cycle while the output is not stalled; a final item adds one
//   flush step per held sample (up to half_width), on the single store read port for flush.
// Reset (synchronous, rst_n low): empty the pipeline, clear sum, count and pointer,
//   load half_width = 1 and scale_recip = 21845; the window store is not cleared.
module centered_moving_average import cma_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  cma_in_if.sink               in_ch,
  cma_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  // Stage 1: item just accepted (or flush step), window store data arrives here.
  typedef struct packed {
    logic                           is_input;
    logic                           emit;
    logic                           sub;
    logic                           full;
    logic                           last;
    logic                           endf;
    logic signed [SAMPLE_WIDTH-1:0] x;
  } s1_t;

  // Stage 2: updated window sum or raw border sample.
  typedef struct packed {
    logic                           avg;
    logic                           endf;
    logic signed [SUM_W-1:0]        sum;
    logic        [SAMPLE_WIDTH-1:0] raw;
  } s2_t;

  // Stage 3: sign and magnitude of the sum.
  typedef struct packed {
    logic                    avg;
    logic                    endf;
    logic                    neg;
    logic [SUM_W-1:0]        mag;
    logic [SAMPLE_WIDTH-1:0] raw;
  } s3_t;

  // Stage 4: magnitude times reciprocal.
  typedef struct packed {
    logic                    avg;
    logic                    endf;
    logic                    neg;
    logic [PROD_W-1:0]       prod;
    logic [SAMPLE_WIDTH-1:0] raw;
  } s4_t;

  // ---------------------------------------------------------------------------
  // Configuration and series state
  // ---------------------------------------------------------------------------
  logic [HW_W-1:0]         half_width_r;
  logic [RECIP_W-1:0]      recip_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [AW-1:0]           wp_r;

  // flush sequencer: walks the held samples oldest first after a final item
  logic                    flush_busy_r;
  logic [HW_W-1:0]         flush_k_r;
  logic [AW-1:0]           flush_base_r;

  // pipeline
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, out_v_r;
  s1_t  s1_r, s1_nxt;
  s2_t  s2_r, s2_nxt;
  s3_t  s3_r, s3_nxt;
  s4_t  s4_r, s4_nxt;
  logic [SAMPLE_WIDTH-1:0] out_smoothed_r, out_smoothed_nxt;
  logic                    out_avg_r, out_end_r;

  // ---------------------------------------------------------------------------
  // Stall chain: a stage takes a new entry when it is empty or its entry moves on.
  // Bubbles collapse, so an item is still taken while a result waits at the output.
  // ---------------------------------------------------------------------------
  logic ld_o, ld4, ld3, ld2, ld1;
  logic acc, flush_ld;

  assign ld_o = !out_v_r || out_ch.ready;
  assign ld4  = !s4_v_r || ld_o;
  assign ld3  = !s3_v_r || ld4;
  assign ld2  = !s2_v_r || ld3;
  assign ld1  = !s1_v_r || ld2;

  assign in_ch.ready = ld1 && !flush_busy_r;
  assign acc         = in_ch.valid && in_ch.ready;
  assign flush_ld    = flush_busy_r && ld1;

  // ---------------------------------------------------------------------------
  // Window position of the arriving item
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0] twop, twop1;
  logic             sub_c, full_c, emit_c, flush_start;
  logic [HW_W-1:0]  k0;
  logic [AW:0]      addr_a_raw, addr_b_raw, addr_f_raw;
  logic [AW-1:0]    addr_a, addr_b, addr_f, ram_addr_b;
  logic [SAMPLE_WIDTH-1:0] rd_a, rd_b;

  always_comb begin
    twop   = CNT_W'({half_width_r, 1'b0});
    twop1  = twop + CNT_W'(1);
    sub_c  = cnt_r >= twop1;               // oldest sample leaves the window
    full_c = cnt_r >= twop;                // a full centered window exists
    emit_c = cnt_r >= CNT_W'(half_width_r);
    flush_start = acc && in_ch.final_sample && (half_width_r != '0);
    // held samples to flush: all of them in a short series, else p of them
    k0 = (cnt_r < CNT_W'(half_width_r)) ? HW_W'(cnt_r) : half_width_r - HW_W'(1);

    // slot 2p+1 back (sample leaving the window) and slot p back (center sample)
    addr_a_raw = {1'b0, wp_r} + (AW + 1)'(DEPTH - 1) - {1'b0, half_width_r, 1'b0};
    addr_b_raw = {1'b0, wp_r} + (AW + 1)'(DEPTH) - (AW + 1)'(half_width_r);
    addr_f_raw = {1'b0, flush_base_r} + (AW + 1)'(DEPTH) - (AW + 1)'(flush_k_r);
    addr_a = (addr_a_raw >= (AW + 1)'(DEPTH)) ? AW'(addr_a_raw - (AW + 1)'(DEPTH))
                                              : addr_a_raw[AW-1:0];
    addr_b = (addr_b_raw >= (AW + 1)'(DEPTH)) ? AW'(addr_b_raw - (AW + 1)'(DEPTH))
                                              : addr_b_raw[AW-1:0];
    addr_f = (addr_f_raw >= (AW + 1)'(DEPTH)) ? AW'(addr_f_raw - (AW + 1)'(DEPTH))
                                              : addr_f_raw[AW-1:0];
    ram_addr_b = flush_busy_r ? addr_f : addr_b;
  end

  // Write the new sample and read both taps at the accepting edge; the store reads
  // old data on a collision, which is what the widest window needs from its oldest slot.
  cma_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (acc),
    .waddr   (wp_r),
    .wdata   (in_ch.sample),
    .re_a    (acc),
    .raddr_a (addr_a),
    .rdata_a (rd_a),
    .re_b    (acc || flush_ld),
    .raddr_b (ram_addr_b),
    .rdata_b (rd_b)
  );

  // ---------------------------------------------------------------------------
  // Stage logic
  // ---------------------------------------------------------------------------
  logic signed [SUM_W-1:0] ev_ext, x_ext, sum_nxt;
  logic [PROD_W:0]         rnd;
  logic [Q_W-1:0]          q;
  logic [SAMPLE_WIDTH-1:0] q_lo, mean;

  always_comb begin
    // stage 1 load: an accepted item, else a flush step
    if (flush_busy_r) begin
      s1_nxt.is_input = 1'b0;
      s1_nxt.emit     = 1'b1;
      s1_nxt.sub      = 1'b0;
      s1_nxt.full     = 1'b0;
      s1_nxt.last     = 1'b0;
      s1_nxt.endf     = (flush_k_r == '0);
      s1_nxt.x        = '0;
    end else begin
      s1_nxt.is_input = 1'b1;
      s1_nxt.emit     = emit_c;
      s1_nxt.sub      = sub_c;
      s1_nxt.full     = full_c;
      s1_nxt.last     = in_ch.final_sample;
      s1_nxt.endf     = in_ch.final_sample && (half_width_r == '0);
      s1_nxt.x        = in_ch.sample;
    end

    // running sum: drop the leaving sample, add the new one
    ev_ext  = s1_r.sub ? SUM_W'($signed(rd_a)) : '0;
    x_ext   = SUM_W'(s1_r.x);
    sum_nxt = sum_r - ev_ext + x_ext;

    s2_nxt.avg  = s1_r.is_input && s1_r.full;
    s2_nxt.endf = s1_r.endf;
    s2_nxt.sum  = sum_nxt;
    s2_nxt.raw  = rd_b;

    s3_nxt.avg  = s2_r.avg;
    s3_nxt.endf = s2_r.endf;
    s3_nxt.neg  = s2_r.sum[SUM_W-1];
    s3_nxt.mag  = s2_r.sum[SUM_W-1] ? $unsigned(-s2_r.sum) : $unsigned(s2_r.sum);
    s3_nxt.raw  = s2_r.raw;

    s4_nxt.avg  = s3_r.avg;
    s4_nxt.endf = s3_r.endf;
    s4_nxt.neg  = s3_r.neg;
    s4_nxt.prod = PROD_W'(s3_r.mag) * PROD_W'(recip_r);
    s4_nxt.raw  = s3_r.raw;

    // round half away from zero on the magnitude, then saturate and restore the sign
    rnd  = {1'b0, s4_r.prod} + (PROD_W + 1)'(2 ** (FRAC_W - 1));
    q    = rnd[PROD_W:FRAC_W];
    q_lo = q[SAMPLE_WIDTH-1:0];
    if (s4_r.neg) begin
      mean = (q > Q_W'(NEG_LIM)) ? SMIN : (~q_lo + SAMPLE_WIDTH'(1));
    end else begin
      mean = (q > Q_W'(POS_LIM)) ? SMAX : q_lo;
    end
    out_smoothed_nxt = s4_r.avg ? mean : s4_r.raw;
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_width_r <= HALF_RESET;
      recip_r      <= RECIP_RESET;
      sum_r        <= '0;
      cnt_r        <= '0;
      wp_r         <= '0;
      flush_busy_r <= 1'b0;
      s1_v_r       <= 1'b0;
      s2_v_r       <= 1'b0;
      s3_v_r       <= 1'b0;
      s4_v_r       <= 1'b0;
      out_v_r      <= 1'b0;
    end else begin
      // sum advances once per item, as the item leaves stage 1
      if (s1_v_r && ld2 && s1_r.is_input) begin
        sum_r <= s1_r.last ? '0 : sum_nxt;
      end

      // advance pointer and count; a final item starts a new series
      if (acc) begin
        if (in_ch.final_sample) begin
          cnt_r <= '0;
          wp_r  <= '0;
        end else begin
          cnt_r <= (cnt_r == CNT_SAT) ? cnt_r : cnt_r + CNT_W'(1);
          wp_r  <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);
        end
      end

      // flush sequencer
      if (flush_start) begin
        flush_busy_r <= 1'b1;
        flush_k_r    <= k0;
        flush_base_r <= wp_r;
      end else if (flush_ld) begin
        if (flush_k_r == '0) begin
          flush_busy_r <= 1'b0;
        end else begin
          flush_k_r <= flush_k_r - HW_W'(1);
        end
      end

      // a new half width abandons the series in progress
      if (cfg_we) begin
        case (cfg_index)
          CFG_HALF_WIDTH: begin
            half_width_r <= (cfg_data[HW_W-1:0] > HW_W'(MAX_HALF)) ? HW_W'(MAX_HALF)
                                                                   : cfg_data[HW_W-1:0];
            sum_r <= '0;
            cnt_r <= '0;
            wp_r  <= '0;
          end
          CFG_SCALE_RECIP: begin
            recip_r <= cfg_data[RECIP_W-1:0];
          end
          default: begin
          end
        endcase
      end

      // pipeline valids; entries that cause no result drop out after stage 1
      if (ld1) begin
        s1_v_r <= acc || flush_ld;
      end
      if (ld2) begin
        s2_v_r <= s1_v_r && s1_r.emit;
      end
      if (ld3) begin
        s3_v_r <= s2_v_r;
      end
      if (ld4) begin
        s4_v_r <= s3_v_r;
      end
      if (ld_o) begin
        out_v_r <= s4_v_r;
      end
    end
  end

  // payload registers: hold while the stage is stalled
  always_ff @(posedge clk) begin
    if (ld1) begin
      s1_r <= s1_nxt;
    end
    if (ld2) begin
      s2_r <= s2_nxt;
    end
    if (ld3) begin
      s3_r <= s3_nxt;
    end
    if (ld4) begin
      s4_r <= s4_nxt;
    end
    if (ld_o) begin
      out_smoothed_r <= out_smoothed_nxt;
      out_avg_r      <= s4_r.avg;
      out_end_r      <= s4_r.endf;
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.smoothed      = $signed(out_smoothed_r);
  assign out_ch.was_averaged  = out_avg_r;
  assign out_ch.end_of_series = out_end_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_flush_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_ch.final_sample && (half_width_r != '0)) |=> flush_busy_r)
    else $error("flush did not start after a final item");

  a_sum_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && ld2 && s1_r.is_input && s1_r.last) |=> (sum_r == '0))
    else $error("window sum not cleared at end of series");

  a_count_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (wp_r == '0))
    else $error("write pointer moved without a counted sample");

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    wp_r < AW'(DEPTH))
    else $error("write pointer out of window store range");

endmodule
